// ===== hw/rtl/vector_integer_element_alu_top_macros.svh =====
// Assertion helpers for the vector integer element ALU.
// Both expect clk and arst_n in scope.
`ifndef VECTOR_INTEGER_ELEMENT_ALU_TOP_MACROS_SVH
`define VECTOR_INTEGER_ELEMENT_ALU_TOP_MACROS_SVH

// same-cycle implication
`define VEIA_ASSERT_NOW(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define VEIA_ASSERT_NEXT(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/veia_pkg.sv =====
`default_nettype none
package veia_pkg;

	localparam int XLEN       = 64;
	localparam int DIV_STAGES = XLEN;
	// stage at which the multiplier result is ready, and the final stage
	localparam int MUL_DONE   = 5;
	localparam int LAST_STAGE = DIV_STAGES + 3;

	localparam logic [4:0] OP_ADD    = 5'd0;
	localparam logic [4:0] OP_SUB    = 5'd1;
	localparam logic [4:0] OP_RSUB   = 5'd2;
	localparam logic [4:0] OP_AND    = 5'd3;
	localparam logic [4:0] OP_OR     = 5'd4;
	localparam logic [4:0] OP_XOR    = 5'd5;
	localparam logic [4:0] OP_SLL    = 5'd6;
	localparam logic [4:0] OP_SRL    = 5'd7;
	localparam logic [4:0] OP_SRA    = 5'd8;
	localparam logic [4:0] OP_MULHU  = 5'd9;
	localparam logic [4:0] OP_MUL    = 5'd10;
	localparam logic [4:0] OP_MULHSU = 5'd11;
	localparam logic [4:0] OP_MULH   = 5'd12;
	localparam logic [4:0] OP_MACC   = 5'd13;
	localparam logic [4:0] OP_NMSAC  = 5'd14;
	localparam logic [4:0] OP_MADD   = 5'd15;
	localparam logic [4:0] OP_NMSUB  = 5'd16;
	localparam logic [4:0] OP_DIVU   = 5'd17;
	localparam logic [4:0] OP_DIV    = 5'd18;
	localparam logic [4:0] OP_REMU   = 5'd19;
	localparam logic [4:0] OP_REM    = 5'd20;
	localparam logic [4:0] OP_MERGE  = 5'd21;
	localparam logic [4:0] OP_MSEQ   = 5'd22;
	localparam logic [4:0] OP_MSNE   = 5'd23;
	localparam logic [4:0] OP_MSLTU  = 5'd24;
	localparam logic [4:0] OP_MSLT   = 5'd25;
	localparam logic [4:0] OP_MSLEU  = 5'd26;
	localparam logic [4:0] OP_MSLE   = 5'd27;
	localparam logic [4:0] OP_MSGTU  = 5'd28;
	localparam logic [4:0] OP_MSGT   = 5'd29;

	typedef struct packed {
		logic [4:0]      mode;
		logic            signed_ops;
		logic [XLEN-1:0] operand_a;
		logic [XLEN-1:0] operand_b;
		logic [XLEN-1:0] old_dest;
		logic            mask_bit;
		logic            unmasked;
		logic            to_mask;
		logic            last_element;
	} item_t;

	typedef struct packed {
		logic            write_enable;
		logic [XLEN-1:0] result_value;
		logic            is_mask_result;
		logic            last;
	} res_t;

	typedef struct packed {
		logic            valid;
		logic [4:0]      mode;
		logic            mask_bit;
		logic            unmasked;
		logic            to_mask;
		logic            last;
		logic [XLEN-1:0] early;
	} side_t;

	typedef struct packed {
		logic high;
		logic neg_prod;
		logic fix_signed;
	} mul_cmd_t;

	typedef struct packed {
		logic signed_op;
		logic want_rem;
	} div_cmd_t;

	function automatic logic is_mul_op(input logic [4:0] m);
		return (m >= OP_MULHU) && (m <= OP_NMSUB);
	endfunction

	function automatic logic is_div_op(input logic [4:0] m);
		return (m >= OP_DIVU) && (m <= OP_REM);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/veia_mul.sv =====
`default_nettype none
module veia_mul (
	input  wire                        clk,
	input  wire                        en,
	input  wire  [veia_pkg::XLEN-1:0]  x,
	input  wire  [veia_pkg::XLEN-1:0]  y,
	input  wire  [veia_pkg::XLEN-1:0]  addend,
	input  wire  [veia_pkg::XLEN-1:0]  sub_t,
	input  wire  [6:0]                 sew,
	input  veia_pkg::mul_cmd_t         cmd,
	output logic [veia_pkg::XLEN-1:0]  res
);
	import veia_pkg::*;

	localparam int H = XLEN / 2;

	logic [XLEN-1:0] ll_s1, lh_s1, hl_s1, hh_s1, c1_s1, add_s1, t_s1;
	mul_cmd_t        cmd_s1;
	logic [2*XLEN-1:0] p_s2;
	logic [XLEN-1:0] c1_s2, add_s2, t_s2;
	mul_cmd_t        cmd_s2;
	logic [XLEN-1:0] hi_s3, lo_s3, low_s3, t_s3;
	mul_cmd_t        cmd_s3;
	logic [XLEN-1:0] res_s4;
	logic [2*XLEN-1:0] shifted;

	assign shifted = {hi_s3, lo_s3} >> sew;

	always_ff @(posedge clk) begin
		if (en) begin
			// 32x32 partial products
			ll_s1  <= XLEN'(x[H-1:0]) * XLEN'(y[H-1:0]);
			lh_s1  <= XLEN'(x[H-1:0]) * XLEN'(y[XLEN-1:H]);
			hl_s1  <= XLEN'(x[XLEN-1:H]) * XLEN'(y[H-1:0]);
			hh_s1  <= XLEN'(x[XLEN-1:H]) * XLEN'(y[XLEN-1:H]);
			c1_s1  <= (x[XLEN-1] ? y : '0) + (y[XLEN-1] ? x : '0);
			add_s1 <= addend;
			t_s1   <= sub_t;
			cmd_s1 <= cmd;

			p_s2   <= {hh_s1, ll_s1} + {(2*XLEN-H-XLEN)'(0), lh_s1, H'(0)}
				+ {(2*XLEN-H-XLEN)'(0), hl_s1, H'(0)};
			c1_s2  <= c1_s1;
			add_s2 <= add_s1;
			t_s2   <= t_s1;
			cmd_s2 <= cmd_s1;

			hi_s3  <= p_s2[2*XLEN-1:XLEN] - (cmd_s2.fix_signed ? c1_s2 : '0);
			lo_s3  <= p_s2[XLEN-1:0];
			low_s3 <= cmd_s2.neg_prod ? add_s2 - p_s2[XLEN-1:0] : add_s2 + p_s2[XLEN-1:0];
			t_s3   <= t_s2;
			cmd_s3 <= cmd_s2;

			res_s4 <= cmd_s3.high ? shifted[XLEN-1:0] - t_s3 : low_s3;
		end
	end

	assign res = res_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/veia_div.sv =====
`default_nettype none
module veia_div (
	input  wire                        clk,
	input  wire                        en,
	input  wire  [veia_pkg::XLEN-1:0]  x,
	input  wire  [veia_pkg::XLEN-1:0]  y,
	input  veia_pkg::div_cmd_t         cmd,
	output logic [veia_pkg::XLEN-1:0]  res
);
	import veia_pkg::*;

	typedef struct packed {
		logic neg_q;
		logic neg_r;
		logic force_ones;
		logic want_rem;
	} div_flags_t;

	// index 0 is the operand stage, 1..DIV_STAGES the restoring steps
	logic [XLEN-1:0] r_s [0:DIV_STAGES];
	logic [XLEN-1:0] n_s [0:DIV_STAGES];
	logic [XLEN-1:0] d_s [0:DIV_STAGES];
	div_flags_t      f_s [0:DIV_STAGES];
	logic [XLEN-1:0] res_sf;

	logic xs, ys;
	assign xs = cmd.signed_op & x[XLEN-1];
	assign ys = cmd.signed_op & y[XLEN-1];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= '0;
			n_s[0] <= xs ? -x : x;
			d_s[0] <= ys ? -y : y;
			f_s[0] <= '{neg_q: xs ^ ys, neg_r: xs,
				force_ones: cmd.signed_op & (y == '0), want_rem: cmd.want_rem};
		end
	end

	for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_step
		logic [XLEN:0]   trial;
		logic [XLEN+1:0] diff;
		logic            ge;
		assign trial = {r_s[i-1], n_s[i-1][XLEN-1]};
		assign diff  = {1'b0, trial} - {2'b00, d_s[i-1]};
		assign ge    = ~diff[XLEN+1];
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i] <= ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
				n_s[i] <= {n_s[i-1][XLEN-2:0], ge};
				d_s[i] <= d_s[i-1];
				f_s[i] <= f_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (f_s[DIV_STAGES].want_rem)
				res_sf <= f_s[DIV_STAGES].neg_r ? -r_s[DIV_STAGES] : r_s[DIV_STAGES];
			else if (f_s[DIV_STAGES].force_ones)
				res_sf <= '1;
			else
				res_sf <= f_s[DIV_STAGES].neg_q ? -n_s[DIV_STAGES] : n_s[DIV_STAGES];
		end
	end

	assign res = res_sf;

endmodule
`default_nettype wire

// ===== hw/rtl/veia_obuf.sv =====
`default_nettype none
module veia_obuf (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  veia_pkg::res_t      push_data,
	input  wire                 pop,
	output logic                valid,
	output veia_pkg::res_t      data,
	output logic                full
);
	import veia_pkg::*;

	res_t       mem_q [2];
	logic [1:0] count_q;
	logic       wr_q, rd_q;
	logic       do_pop;

	assign valid  = count_q != 2'd0;
	assign full   = count_q == 2'd2;
	assign do_pop = pop & valid;
	assign data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			if (push)   wr_q <= ~wr_q;
			if (do_pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/vector_integer_element_alu_top.sv =====
// Vector integer element ALU. One element word per cycle enters on item,
// while item_ready is high, and leaves on res, in order, one result per
// element. An item taken passes 67 pipeline registers (the operand stage,
// then 66 stages set by the divider, a restoring unit with one quotient bit
// per stage over 64 stages plus its operand and sign-fix stages) and then
// the output buffer before its result can be taken.
// Every op travels the same depth so order is kept. Multiplies use four
// 32x32 partial products over four stages. A two-word output buffer takes
// results, so item_ready drops only once it holds two unread words. SEW
// comes from cfg_data (0:8, 1:16, 2:32, 3:64 bits, capped at
// MAX_ELEMENT_BITS); cfg writes are always taken and must only be issued
// while the unit is empty.
// Operands are widened to 64 bits (sign or zero per signed_ops), the op
// runs on 64 bits, and the result is cut back to SEW, or to bit 0 for mask
// destinations. Masked-off elements come out with write_enable low and 0.
`default_nettype none
`include "vector_integer_element_alu_top_macros.svh"
module vector_integer_element_alu_top #(
	parameter int MAX_ELEMENT_BITS = 64
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_ready,
	input  veia_pkg::item_t    item,
	output logic               res_valid,
	input  wire                res_ready,
	output veia_pkg::res_t     res,
	input  wire                cfg_valid,
	output logic               cfg_ready,
	input  wire  [1:0]         cfg_data
);
	import veia_pkg::*;

	function automatic logic [6:0] sew_of(input logic [1:0] code);
		logic [6:0] w;
		w = 7'd8 << code;
		if (32'(w) > MAX_ELEMENT_BITS) w = 7'(MAX_ELEMENT_BITS);
		return w;
	endfunction

	function automatic logic [XLEN-1:0] mask_of(input logic [6:0] w);
		return (w >= 7'(XLEN)) ? '1 : (XLEN'(1) << w) - XLEN'(1);
	endfunction

	// SEW-derived settings, kept as registers
	logic [6:0]      sew_q;
	logic [5:0]      sidx_q;
	logic [XLEN-1:0] mask_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sew_q  <= sew_of(2'd0);
			sidx_q <= 6'(sew_of(2'd0) - 7'd1);
			mask_q <= mask_of(sew_of(2'd0));
		end else if (cfg_valid) begin
			sew_q  <= sew_of(cfg_data);
			sidx_q <= 6'(sew_of(cfg_data) - 7'd1);
			mask_q <= mask_of(sew_of(cfg_data));
		end
	end

	// pipeline advance; only a full output buffer holds things up
	logic adv, buf_full;
	assign adv        = ~buf_full;
	assign item_ready = adv;

	// widening of the incoming operands
	logic [XLEN-1:0] az, bz, dz, ax, bx, dx;
	assign az = item.operand_a & mask_q;
	assign bz = item.operand_b & mask_q;
	assign dz = item.old_dest  & mask_q;
	assign ax = az | ({XLEN{item.operand_a[sidx_q]}} & ~mask_q);
	assign bx = bz | ({XLEN{item.operand_b[sidx_q]}} & ~mask_q);
	assign dx = dz | ({XLEN{item.old_dest[sidx_q]}} & ~mask_q);

	// stage 1: widened operands
	logic            v_s1;
	logic [4:0]      mode_s1;
	logic            mbit_s1, vm_s1, tom_s1, last_s1;
	logic [XLEN-1:0] a_s1, b_s1, d_s1, sa_s1, sb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= item.mode;
			mbit_s1 <= item.mask_bit;
			vm_s1   <= item.unmasked;
			tom_s1  <= item.to_mask;
			last_s1 <= item.last_element;
			a_s1    <= item.signed_ops ? ax : az;
			b_s1    <= item.signed_ops ? bx : bz;
			d_s1    <= item.signed_ops ? dx : dz;
			sa_s1   <= ax;
			sb_s1   <= bx;
		end
	end

	// ops computed combinationally in stage 1
	logic [5:0]      sh;
	logic [XLEN-1:0] alu;
	assign sh = b_s1[5:0] & sidx_q;

	always_comb begin
		unique case (mode_s1)
			OP_ADD:   alu = a_s1 + b_s1;
			OP_SUB:   alu = a_s1 - b_s1;
			OP_RSUB:  alu = b_s1 - a_s1;
			OP_AND:   alu = a_s1 & b_s1;
			OP_OR:    alu = a_s1 | b_s1;
			OP_XOR:   alu = a_s1 ^ b_s1;
			OP_SLL:   alu = a_s1 << sh;
			OP_SRL:   alu = a_s1 >> sh;
			OP_SRA:   alu = XLEN'($signed(sa_s1) >>> sh);
			OP_MERGE: alu = (vm_s1 | mbit_s1) ? b_s1 : a_s1;
			OP_MSEQ:  alu = XLEN'(a_s1 == b_s1);
			OP_MSNE:  alu = XLEN'(a_s1 != b_s1);
			OP_MSLTU: alu = XLEN'(a_s1 < b_s1);
			OP_MSLT:  alu = XLEN'($signed(a_s1) < $signed(b_s1));
			OP_MSLEU: alu = XLEN'(a_s1 <= b_s1);
			OP_MSLE:  alu = XLEN'($signed(a_s1) <= $signed(b_s1));
			OP_MSGTU: alu = XLEN'(a_s1 > b_s1);
			OP_MSGT:  alu = XLEN'($signed(a_s1) > $signed(b_s1));
			default:  alu = b_s1;  // unused codes pass b; mul/div overwritten later
		endcase
	end

	// multiplier set-up
	logic [XLEN-1:0] mx, my, madd_v, mt;
	mul_cmd_t        mcmd;
	logic [XLEN-1:0] mul_res;

	always_comb begin
		mx     = a_s1;
		my     = b_s1;
		madd_v = '0;
		mt     = '0;
		mcmd   = '{high: 1'b0, neg_prod: 1'b0, fix_signed: 1'b0};
		unique case (mode_s1)
			OP_MULHU:  mcmd.high = 1'b1;
			OP_MULHSU: begin
				mcmd.high = 1'b1;
				mt        = sa_s1[XLEN-1] ? b_s1 : '0;
			end
			OP_MULH: begin
				mx              = sa_s1;
				my              = sb_s1;
				mcmd.high       = 1'b1;
				mcmd.fix_signed = 1'b1;
			end
			OP_MACC:  madd_v = d_s1;
			OP_NMSAC: begin
				madd_v        = d_s1;
				mcmd.neg_prod = 1'b1;
			end
			OP_MADD: begin
				mx     = d_s1;
				madd_v = a_s1;
			end
			OP_NMSUB: begin
				mx            = d_s1;
				madd_v        = a_s1;
				mcmd.neg_prod = 1'b1;
			end
			default: ;
		endcase
	end

	veia_mul u_mul (
		.clk    (clk),
		.en     (adv),
		.x      (mx),
		.y      (my),
		.addend (madd_v),
		.sub_t  (mt),
		.sew    (sew_q),
		.cmd    (mcmd),
		.res    (mul_res)
	);

	// divider set-up: signed forms use the SEW-sign-extended operands
	div_cmd_t        dcmd;
	logic [XLEN-1:0] div_res;
	assign dcmd.signed_op = (mode_s1 == OP_DIV) || (mode_s1 == OP_REM);
	assign dcmd.want_rem  = (mode_s1 == OP_REMU) || (mode_s1 == OP_REM);

	veia_div u_div (
		.clk (clk),
		.en  (adv),
		.x   (dcmd.signed_op ? sa_s1 : a_s1),
		.y   (dcmd.signed_op ? sb_s1 : b_s1),
		.cmd (dcmd),
		.res (div_res)
	);

	// sideband carried alongside the units, stages 2 to LAST_STAGE
	side_t side_s [2:LAST_STAGE];
	side_t side_mul;

	// multiplier result lines up with stage MUL_DONE
	always_comb begin
		side_mul = side_s[MUL_DONE];
		if (is_mul_op(side_s[MUL_DONE].mode))
			side_mul.early = mul_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 2; k <= LAST_STAGE; k++) side_s[k] <= '0;
		end else if (adv) begin
			side_s[2] <= '{valid: v_s1, mode: mode_s1, mask_bit: mbit_s1,
				unmasked: vm_s1, to_mask: tom_s1, last: last_s1, early: alu};
			for (int k = 3; k <= LAST_STAGE; k++) begin
				if (k == MUL_DONE + 1)
					side_s[k] <= side_mul;
				else
					side_s[k] <= side_s[k-1];
			end
		end
	end

	// final select and masking
	side_t           fin;
	logic [XLEN-1:0] r;
	logic            off;
	res_t            res_d;

	assign fin = side_s[LAST_STAGE];
	assign r   = is_div_op(fin.mode) ? div_res : fin.early;
	assign off = ~fin.unmasked & (fin.mode != OP_MERGE) & ~fin.mask_bit;

	always_comb begin
		res_d.write_enable   = ~off;
		res_d.is_mask_result = fin.to_mask;
		res_d.last           = fin.last;
		if (off)
			res_d.result_value = '0;
		else if (fin.to_mask)
			res_d.result_value = {{(XLEN-1){1'b0}}, r[0]};
		else
			res_d.result_value = r & mask_q;
	end

	veia_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fin.valid & adv),
		.push_data (res_d),
		.pop       (res_ready),
		.valid     (res_valid),
		.data      (res),
		.full      (buf_full)
	);

	`VEIA_ASSERT_NOW(a_off_zero, res_valid && !res.write_enable,
		res.result_value == '0, "masked-off word carries data")
	`VEIA_ASSERT_NOW(a_mask_one_bit, res_valid && res.is_mask_result,
		res.result_value[XLEN-1:1] == '0, "mask result wider than one bit")
	`VEIA_ASSERT_NEXT(a_hold_last, fin.valid && !adv, side_s[LAST_STAGE].valid,
		"final-stage word lost during stall")

endmodule
`default_nettype wire
